### hdl/gipps_car_following_step_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Gipps car-following step block
// Each macro expands to a clocked concurrent assertion, or to nothing when
// assertions are switched off at compile time.
// ----------------------------------------------------------------------------
`ifndef GIPPS_CAR_FOLLOWING_STEP_ASSERT_SVH
`define GIPPS_CAR_FOLLOWING_STEP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define GCF_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("gcf assertion failed");

// next-cycle implication
`define GCF_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("gcf assertion failed");

`else

`define GCF_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define GCF_ASSERT_NXT(lbl, ck, rn, ante, cons)

`endif

`endif

### hdl/gcf_pkg.sv
// ----------------------------------------------------------------------------
// gcf_pkg
// Shared types and codes for the Gipps car-following step block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gcf_pkg;

	// register indexes (byte address is 4 * index)
	localparam logic [2:0] REG_TIME_STEP     = 3'd0;
	localparam logic [2:0] REG_REACTION_TIME = 3'd1;
	localparam logic [2:0] REG_MAX_ACCEL     = 3'd2;
	localparam logic [2:0] REG_DESIRED_DECEL = 3'd3;
	localparam logic [2:0] REG_DESIRED_SPEED = 3'd4;
	localparam logic [2:0] REG_LEADER_DECEL  = 3'd5;
	localparam logic [2:0] REG_LEADER_LENGTH = 3'd6;

	// shared unit operations
	localparam logic [1:0] OP_MUL  = 2'd0;
	localparam logic [1:0] OP_DIV  = 2'd1;
	localparam logic [1:0] OP_SQRT = 2'd2;

	// shared unit geometry
	localparam int OPA_W   = 52;
	localparam int OPB_W   = 32;
	localparam int RES_W   = OPA_W + OPB_W;
	localparam int ROOT_W  = OPA_W / 2;
	localparam int REM_W   = ROOT_W + 3;

	typedef struct packed {
		logic [15:0] time_step;
		logic [15:0] reaction_time;
		logic [11:0] max_accel;
		logic [12:0] desired_decel;
		logic [15:0] desired_speed;
		logic [12:0] leader_decel_estimate;
		logic [12:0] leader_length;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [1:0]       op;
		logic [OPA_W-1:0] a;
		logic [OPB_W-1:0] b;
	} unit_req_t;

	typedef struct packed {
		logic             done;
		logic [RES_W-1:0] res;
	} unit_rsp_t;

endpackage

`default_nettype wire

### hdl/gcf_unit.sv
// ----------------------------------------------------------------------------
// gcf_unit
// Shared bit-serial arithmetic unit: unsigned multiply (32 steps), unsigned
// restoring divide (32 steps) and floor square root (26 steps).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gcf_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire gcf_pkg::unit_req_t req,
	output gcf_pkg::unit_rsp_t     rsp
);

	logic                      busy_q;
	logic                      done_q;
	logic [1:0]                op_q;
	logic [5:0]                cnt_q;
	logic [gcf_pkg::OPA_W-1:0] a_q;
	logic [gcf_pkg::OPB_W-1:0] b_q;
	logic [gcf_pkg::OPA_W-1:0] hi_q;
	logic [gcf_pkg::OPB_W-1:0] lo_q;

	logic [gcf_pkg::OPA_W:0]   mul_sum;
	logic [gcf_pkg::OPB_W:0]   div_trial;
	logic [gcf_pkg::OPB_W:0]   div_diff;
	logic [gcf_pkg::REM_W-1:0] sq_rem;
	logic [gcf_pkg::REM_W-1:0] sq_trial;

	// one step of each operation
	always_comb begin
		mul_sum   = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);
		div_trial = {hi_q[gcf_pkg::OPB_W-1:0], lo_q[gcf_pkg::OPB_W-1]};
		div_diff  = div_trial - {1'b0, b_q};
		sq_rem    = {hi_q[gcf_pkg::REM_W-3:0], a_q[gcf_pkg::OPA_W-1 -: 2]};
		sq_trial  = {1'b0, lo_q[gcf_pkg::ROOT_W-1:0], 2'b01};
	end

	// sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= gcf_pkg::OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= (req.op == gcf_pkg::OP_SQRT) ? 6'(gcf_pkg::ROOT_W - 1)
					: 6'(gcf_pkg::OPB_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand and partial result registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q  <= req.a;
			b_q  <= req.b;
			hi_q <= '0;
			case (req.op)
				gcf_pkg::OP_MUL: lo_q <= req.b;
				gcf_pkg::OP_DIV: lo_q <= req.a[gcf_pkg::OPB_W-1:0];
				default:         lo_q <= '0;
			endcase
		end else if (busy_q) begin
			case (op_q)
				gcf_pkg::OP_MUL: begin
					hi_q <= mul_sum[gcf_pkg::OPA_W:1];
					lo_q <= {mul_sum[0], lo_q[gcf_pkg::OPB_W-1:1]};
				end
				gcf_pkg::OP_DIV: begin
					if (!div_diff[gcf_pkg::OPB_W]) begin
						hi_q <= {{(gcf_pkg::OPA_W-gcf_pkg::OPB_W){1'b0}},
							div_diff[gcf_pkg::OPB_W-1:0]};
						lo_q <= {lo_q[gcf_pkg::OPB_W-2:0], 1'b1};
					end else begin
						hi_q <= {{(gcf_pkg::OPA_W-gcf_pkg::OPB_W){1'b0}},
							div_trial[gcf_pkg::OPB_W-1:0]};
						lo_q <= {lo_q[gcf_pkg::OPB_W-2:0], 1'b0};
					end
				end
				gcf_pkg::OP_SQRT: begin
					a_q <= {a_q[gcf_pkg::OPA_W-3:0], 2'b00};
					if (sq_rem >= sq_trial) begin
						hi_q <= gcf_pkg::OPA_W'(sq_rem - sq_trial);
						lo_q <= {lo_q[gcf_pkg::OPB_W-2:0], 1'b1};
					end else begin
						hi_q <= gcf_pkg::OPA_W'(sq_rem);
						lo_q <= {lo_q[gcf_pkg::OPB_W-2:0], 1'b0};
					end
				end
				default: begin
					hi_q <= hi_q;
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = {hi_q, lo_q};

endmodule

`default_nettype wire

### hdl/gcf_regs.sv
// ----------------------------------------------------------------------------
// gcf_regs
// APB-style configuration registers of the Gipps step block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gcf_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output gcf_pkg::cfg_t    cfg
);

	gcf_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// write registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_step             <= 16'd1024;
			cfg_q.reaction_time         <= 16'd682;
			cfg_q.max_accel             <= 12'd512;
			cfg_q.desired_decel         <= 13'h1D00;
			cfg_q.desired_speed         <= 16'd7680;
			cfg_q.leader_decel_estimate <= 13'h1D00;
			cfg_q.leader_length         <= 13'd1664;
		end else if (wr_en) begin
			case (paddr[4:2])
				gcf_pkg::REG_TIME_STEP:     cfg_q.time_step <= pwdata[15:0];
				gcf_pkg::REG_REACTION_TIME: cfg_q.reaction_time <= pwdata[15:0];
				gcf_pkg::REG_MAX_ACCEL:     cfg_q.max_accel <= pwdata[11:0];
				gcf_pkg::REG_DESIRED_DECEL: cfg_q.desired_decel <= pwdata[12:0];
				gcf_pkg::REG_DESIRED_SPEED: cfg_q.desired_speed <= pwdata[15:0];
				gcf_pkg::REG_LEADER_DECEL:  cfg_q.leader_decel_estimate <= pwdata[12:0];
				gcf_pkg::REG_LEADER_LENGTH: cfg_q.leader_length <= pwdata[12:0];
				default:                    cfg_q <= cfg_q;
			endcase
		end
	end

	// read back
	always_comb begin
		case (paddr[4:2])
			gcf_pkg::REG_TIME_STEP:     prdata = {16'd0, cfg_q.time_step};
			gcf_pkg::REG_REACTION_TIME: prdata = {16'd0, cfg_q.reaction_time};
			gcf_pkg::REG_MAX_ACCEL:     prdata = {20'd0, cfg_q.max_accel};
			gcf_pkg::REG_DESIRED_DECEL: prdata = {19'd0, cfg_q.desired_decel};
			gcf_pkg::REG_DESIRED_SPEED: prdata = {16'd0, cfg_q.desired_speed};
			gcf_pkg::REG_LEADER_DECEL:  prdata = {19'd0, cfg_q.leader_decel_estimate};
			gcf_pkg::REG_LEADER_LENGTH: prdata = {19'd0, cfg_q.leader_length};
			default:                    prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

### hdl/gcf_core.sv
// ----------------------------------------------------------------------------
// gcf_core
// Sequencer and datapath registers: walks one step of the Gipps model
// through the shared arithmetic unit and holds the follower state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gcf_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire gcf_pkg::cfg_t      cfg,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic               op,
	input  wire logic signed [31:0] init_position,
	input  wire logic [15:0]        init_speed,
	input  wire logic signed [31:0] leader_pos_prev,
	input  wire logic [15:0]        leader_speed_prev,
	input  wire logic               leader_speed_known,
	input  wire logic signed [31:0] leader_pos_now,
	input  wire logic [15:0]        leader_speed_now,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic [15:0]             follower_speed,
	output logic signed [31:0]      follower_position,
	output logic signed [15:0]      acceleration,
	output logic signed [31:0]      spacing,
	output logic signed [16:0]      speed_diff,
	output logic [15:0]             free_speed,
	output logic signed [16:0]      follow_speed,
	output logic                    radicand_negative
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RQ   = 4'd1;
	localparam logic [3:0] ST_SQF  = 4'd2;
	localparam logic [3:0] ST_MP   = 4'd3;
	localparam logic [3:0] ST_MK   = 4'd4;
	localparam logic [3:0] ST_MMAG = 4'd5;
	localparam logic [3:0] ST_MBT  = 4'd6;
	localparam logic [3:0] ST_MBT2 = 4'd7;
	localparam logic [3:0] ST_MVT  = 4'd8;
	localparam logic [3:0] ST_MUL2 = 4'd9;
	localparam logic [3:0] ST_DUC  = 4'd10;
	localparam logic [3:0] ST_MBD  = 4'd11;
	localparam logic [3:0] ST_SQC  = 4'd12;
	localparam logic [3:0] ST_MPOS = 4'd13;
	localparam logic [3:0] ST_DACC = 4'd14;
	localparam logic [3:0] ST_OUT  = 4'd15;

	gcf_pkg::unit_req_t req;
	gcf_pkg::unit_rsp_t rsp;

	logic [3:0]          state_q;
	logic                issued_q;

	// follower state and latched item
	logic [15:0]         v_q;
	logic signed [31:0]  x_q;
	logic signed [31:0]  xl_q;
	logic [15:0]         ul_q;
	logic signed [31:0]  xn_q;
	logic [15:0]         un_q;

	// intermediate results
	logic [31:0]         rq_q;
	logic [24:0]         s_q;
	logic [41:0]         p_q;
	logic [30:0]         k_q;
	logic [15:0]         ff_q;
	logic [27:0]         btm_q;
	logic [35:0]         rada_q;
	logic signed [37:0]  dbase_q;
	logic [31:0]         ul2_q;
	logic signed [37:0]  d_q;
	logic [50:0]         rad_q;
	logic                radneg_q;
	logic signed [16:0]  cf_q;
	logic signed [31:0]  pos_q;

	// derived values
	logic [15:0]         dt;
	logic [15:0]         vd;
	logic                bneg;
	logic [12:0]         bmag;
	logic [12:0]         c_eff;
	logic                cneg;
	logic [12:0]         cmag;
	logic                ff_neg;
	logic [31:0]         om;
	logic [45:0]         mag;
	logic [46:0]         ff_sum;
	logic [15:0]         ff_new;
	logic [21:0]         vt;
	logic signed [37:0]  dbase_new;
	logic signed [37:0]  d_new;
	logic                dneg;
	logic [37:0]         dmag;
	logic [51:0]         rad_new;
	logic [17:0]         btsh;
	logic signed [27:0]  cfs;
	logic signed [16:0]  cf_new;
	logic [15:0]         vn;
	logic signed [33:0]  posw;
	logic signed [31:0]  pos_new;
	logic signed [33:0]  spw;
	logic signed [31:0]  spc_new;
	logic signed [16:0]  dv;
	logic [16:0]         dvmag;
	logic [31:0]         qacc;
	logic [15:0]         acc_new;
	logic                accept;

	gcf_unit u_unit (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	assign accept       = item_valid && !item_stall;
	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = (state_q == ST_OUT);

	// fixed point terms of the model
	always_comb begin
		dt     = (cfg.time_step == 16'd0) ? 16'd1 : cfg.time_step;
		vd     = (cfg.desired_speed == 16'd0) ? 16'd1 : cfg.desired_speed;
		bneg   = cfg.desired_decel[12];
		bmag   = bneg ? 13'(-cfg.desired_decel) : cfg.desired_decel;
		c_eff  = (cfg.leader_decel_estimate == 13'd0) ? 13'h1FFF
			: cfg.leader_decel_estimate;
		cneg   = c_eff[12];
		cmag   = cneg ? 13'(-c_eff) : c_eff;

		// free-flow term
		ff_neg = rq_q > 32'd65536;
		om     = ff_neg ? (rq_q - 32'd65536) : (32'd65536 - rq_q);
		mag    = rsp.res[72:27];
		ff_sum = {31'd0, v_q} + {1'b0, mag};
		if (ff_neg) begin
			ff_new = ({30'd0, v_q} < mag) ? 16'd0 : 16'(v_q - mag[15:0]);
		end else begin
			ff_new = (ff_sum > 47'd65535) ? 16'hFFFF : ff_sum[15:0];
		end

		// car-following terms
		vt        = rsp.res[31:10];
		dbase_new = ((38'(xl_q) - $signed({25'd0, cfg.leader_length}) - 38'(x_q)) <<< 1)
			- $signed({16'd0, vt});
		d_new     = cneg ? (dbase_q + $signed({6'd0, rsp.res[31:0]}))
			: (dbase_q - $signed({6'd0, rsp.res[31:0]}));
		dneg      = d_q[37];
		dmag      = dneg ? 38'(-d_q) : d_q;
		rad_new   = (bneg ^ dneg) ? ({16'd0, rada_q} + {2'd0, rsp.res[49:0]})
			: ({16'd0, rada_q} - {2'd0, rsp.res[49:0]});
		btsh      = btm_q[27:10];
		cfs       = $signed({2'd0, rsp.res[gcf_pkg::ROOT_W-1:0]})
			+ (bneg ? -$signed({10'd0, btsh}) : $signed({10'd0, btsh}));
		if (cfs > 28'sd65535) begin
			cf_new = 17'sd65535;
		end else if (cfs < -28'sd65535) begin
			cf_new = -17'sd65535;
		end else begin
			cf_new = cfs[16:0];
		end

		// new speed: smaller candidate, clamped at zero
		if (cf_q[16] || cf_q == 17'sd0) begin
			vn = 16'd0;
		end else begin
			vn = (ff_q < cf_q[15:0]) ? ff_q : cf_q[15:0];
		end

		// position and spacing, saturated
		posw = 34'(x_q) + $signed({12'd0, rsp.res[32:11]});
		pos_new = (posw > 34'sd2147483647) ? 32'sh7FFFFFFF : posw[31:0];
		spw  = 34'(xn_q) - 34'(pos_q);
		if (spw > 34'sd2147483647) begin
			spc_new = 32'sh7FFFFFFF;
		end else if (spw < -34'sd2147483648) begin
			spc_new = 32'sh80000000;
		end else begin
			spc_new = spw[31:0];
		end

		// acceleration, truncated toward zero and saturated
		dv    = $signed({1'b0, vn}) - $signed({1'b0, v_q});
		dvmag = dv[16] ? 17'(-dv) : dv;
		qacc  = rsp.res[31:0];
		if (dv[16]) begin
			acc_new = (qacc > 32'd32768) ? 16'h8000 : 16'(~qacc[15:0] + 16'd1);
		end else begin
			acc_new = (qacc > 32'd32767) ? 16'h7FFF : qacc[15:0];
		end
	end

	// operands for the shared unit
	always_comb begin
		req.start = (state_q != ST_IDLE) && (state_q != ST_OUT) && !issued_q
			&& !((state_q == ST_SQC) && radneg_q);
		req.op    = gcf_pkg::OP_MUL;
		req.a     = '0;
		req.b     = '0;
		case (state_q)
			ST_RQ: begin
				req.op = gcf_pkg::OP_DIV;
				req.a  = {20'd0, v_q, 16'd0};
				req.b  = {16'd0, vd};
			end
			ST_SQF: begin
				req.op = gcf_pkg::OP_SQRT;
				req.a  = {3'd0, (33'(rq_q) + 33'd1638), 16'd0};
			end
			ST_MP: begin
				req.a = {20'd0, om};
				req.b = {7'd0, s_q};
			end
			ST_MK: begin
				req.a = {37'd0, ({3'd0, cfg.max_accel} + {1'b0, cfg.max_accel, 2'b00})};
				req.b = {16'd0, cfg.reaction_time};
			end
			ST_MMAG: begin
				req.a = {10'd0, p_q};
				req.b = {1'b0, k_q};
			end
			ST_MBT: begin
				req.a = {39'd0, bmag};
				req.b = {16'd0, cfg.reaction_time};
			end
			ST_MBT2: begin
				req.a = {24'd0, btm_q};
				req.b = {4'd0, btm_q};
			end
			ST_MVT: begin
				req.a = {36'd0, v_q};
				req.b = {16'd0, cfg.reaction_time};
			end
			ST_MUL2: begin
				req.a = {36'd0, ul_q};
				req.b = {16'd0, ul_q};
			end
			ST_DUC: begin
				req.op = gcf_pkg::OP_DIV;
				req.a  = {20'd0, ul2_q};
				req.b  = {19'd0, cmag};
			end
			ST_MBD: begin
				req.a = {14'd0, dmag};
				req.b = {19'd0, bmag};
			end
			ST_SQC: begin
				req.op = gcf_pkg::OP_SQRT;
				req.a  = {1'b0, rad_q};
			end
			ST_MPOS: begin
				req.a = {35'd0, ({1'b0, v_q} + {1'b0, vn})};
				req.b = {16'd0, dt};
			end
			ST_DACC: begin
				req.op = gcf_pkg::OP_DIV;
				req.a  = {26'd0, dvmag[15:0], 10'd0};
				req.b  = {16'd0, dt};
			end
			default: begin
				req.op = gcf_pkg::OP_MUL;
			end
		endcase
	end

	// sequencer and follower state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issued_q <= 1'b0;
			v_q      <= 16'd0;
			x_q      <= 32'sd0;
		end else begin
			if (req.start) begin
				issued_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (op) begin
							state_q <= ST_RQ;
						end else begin
							v_q <= init_speed;
							x_q <= init_position;
						end
					end
				end
				ST_SQC: begin
					if (radneg_q) begin
						state_q <= ST_MPOS;
					end else if (rsp.done) begin
						issued_q <= 1'b0;
						state_q  <= ST_MPOS;
					end
				end
				ST_DACC: begin
					if (rsp.done) begin
						issued_q <= 1'b0;
						state_q  <= ST_OUT;
						v_q      <= vn;
						x_q      <= pos_q;
					end
				end
				ST_OUT: begin
					if (!result_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					if (rsp.done) begin
						issued_q <= 1'b0;
						state_q  <= state_q + 4'd1;
					end
				end
			endcase
		end
	end

	// capture item fields and unit results
	always_ff @(posedge clk) begin
		if (accept && op) begin
			xl_q <= leader_pos_prev;
			ul_q <= leader_speed_known ? leader_speed_prev : 16'd0;
			xn_q <= leader_pos_now;
			un_q <= leader_speed_now;
		end
		if (rsp.done) begin
			case (state_q)
				ST_RQ:   rq_q    <= rsp.res[31:0];
				ST_SQF:  s_q     <= rsp.res[24:0];
				ST_MP:   p_q     <= rsp.res[57:16];
				ST_MK:   k_q     <= rsp.res[30:0];
				ST_MMAG: ff_q    <= ff_new;
				ST_MBT:  btm_q   <= rsp.res[27:0];
				ST_MBT2: rada_q  <= rsp.res[55:20];
				ST_MVT:  dbase_q <= dbase_new;
				ST_MUL2: ul2_q   <= rsp.res[31:0];
				ST_DUC:  d_q     <= d_new;
				ST_SQC:  cf_q    <= cf_new;
				ST_MPOS: pos_q   <= pos_new;
				default: pos_q   <= pos_q;
			endcase
		end
		// the radicand sign decides whether the root is taken
		if (rsp.done && state_q == ST_MBD) begin
			rad_q    <= rad_new[50:0];
			radneg_q <= rad_new[51];
			if (rad_new[51]) begin
				cf_q <= 17'sd0;
			end
		end
		// load the result registers
		if (rsp.done && state_q == ST_DACC) begin
			follower_speed    <= vn;
			follower_position <= pos_q;
			acceleration      <= acc_new;
			spacing           <= spc_new;
			speed_diff        <= $signed({1'b0, vn}) - $signed({1'b0, un_q});
			free_speed        <= ff_q;
			follow_speed      <= cf_q;
			radicand_negative <= radneg_q;
		end
	end

endmodule

`default_nettype wire

### hdl/gipps_car_following_step.sv
// ----------------------------------------------------------------------------
// gipps_car_following_step
// A step item runs 9 multiplies, 3 divides and 2 square roots on one shared
// bit-serial unit, one after another; a negative radicand skips the car-following root.
// No new item is taken until the step result has been taken; a load item sets
// the follower state, gives no result and leaves the block ready for the next item.
// Reset restores register defaults and clears follower speed and position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "gipps_car_following_step_assert.svh"

module gipps_car_following_step (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic               op,
	input  wire logic signed [31:0] init_position,
	input  wire logic [15:0]        init_speed,
	input  wire logic signed [31:0] leader_pos_prev,
	input  wire logic [15:0]        leader_speed_prev,
	input  wire logic               leader_speed_known,
	input  wire logic signed [31:0] leader_pos_now,
	input  wire logic [15:0]        leader_speed_now,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic [15:0]             follower_speed,
	output logic signed [31:0]      follower_position,
	output logic signed [15:0]      acceleration,
	output logic signed [31:0]      spacing,
	output logic signed [16:0]      speed_diff,
	output logic [15:0]             free_speed,
	output logic signed [16:0]      follow_speed,
	output logic                    radicand_negative
);

	gcf_pkg::cfg_t cfg;

	gcf_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	gcf_core u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.item_valid        (item_valid),
		.item_stall        (item_stall),
		.op                (op),
		.init_position     (init_position),
		.init_speed        (init_speed),
		.leader_pos_prev   (leader_pos_prev),
		.leader_speed_prev (leader_speed_prev),
		.leader_speed_known(leader_speed_known),
		.leader_pos_now    (leader_pos_now),
		.leader_speed_now  (leader_speed_now),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.follower_speed    (follower_speed),
		.follower_position (follower_position),
		.acceleration      (acceleration),
		.spacing           (spacing),
		.speed_diff        (speed_diff),
		.free_speed        (free_speed),
		.follow_speed      (follow_speed),
		.radicand_negative (radicand_negative)
	);

	// no new item while a result waits
	`GCF_ASSERT_IMP(a_stall_on_result, clk, arst_n, result_valid, item_stall)
	// new speed never exceeds the free-flow candidate
	`GCF_ASSERT_IMP(a_speed_le_free, clk, arst_n, result_valid, follower_speed <= free_speed)
	// a negative radicand forces the car-following candidate to zero
	`GCF_ASSERT_IMP(a_neg_rad_zero, clk, arst_n, result_valid && radicand_negative,
		follow_speed == 17'sd0)
	// an accepted step item keeps the input side stalled next cycle
	`GCF_ASSERT_NXT(a_step_busy, clk, arst_n, item_valid && !item_stall && op, item_stall)

endmodule

`default_nettype wire

### tb/gipps_car_following_step_tb.sv
// ----------------------------------------------------------------------------
// Gipps car-following step testbench
// Drives load and step items through the block under several register
// settings and compares every result with a bit-exact fixed-point predictor
// kept inside a small scoreboard class. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gipps_car_following_step_tb;

	localparam bit OPC_LOAD = 1'b0;
	localparam bit OPC_STEP = 1'b1;

	typedef struct {
		bit                op;
		logic signed [31:0] init_position;
		logic [15:0]        init_speed;
		logic signed [31:0] leader_pos_prev;
		logic [15:0]        leader_speed_prev;
		bit                 leader_speed_known;
		logic signed [31:0] leader_pos_now;
		logic [15:0]        leader_speed_now;
	} vehicle_item_t;

	typedef struct {
		logic [15:0]        follower_speed;
		logic signed [31:0] follower_position;
		logic signed [15:0] acceleration;
		logic signed [31:0] spacing;
		logic signed [16:0] speed_diff;
		logic [15:0]        free_speed;
		logic signed [16:0] follow_speed;
		logic               radicand_negative;
	} step_result_t;

	// Follower predictor and queue of expected step results
	class follower_tracker;
		gcf_pkg::cfg_t  regs;
		logic [15:0]    speed_now;
		logic [31:0]    position_now;
		step_result_t   pending_steps[$];
		int             errors;
		int             checked;

		function new();
			regs.time_step             = 16'd1024;
			regs.reaction_time         = 16'd682;
			regs.max_accel             = 12'd512;
			regs.desired_decel         = 13'h1D00;
			regs.desired_speed         = 16'd7680;
			regs.leader_decel_estimate = 13'h1D00;
			regs.leader_length         = 13'd1664;
			speed_now = '0;
			position_now = '0;
			errors = 0;
			checked = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				gcf_pkg::REG_TIME_STEP:     regs.time_step = val[15:0];
				gcf_pkg::REG_REACTION_TIME: regs.reaction_time = val[15:0];
				gcf_pkg::REG_MAX_ACCEL:     regs.max_accel = val[11:0];
				gcf_pkg::REG_DESIRED_DECEL: regs.desired_decel = val[12:0];
				gcf_pkg::REG_DESIRED_SPEED: regs.desired_speed = val[15:0];
				gcf_pkg::REG_LEADER_DECEL:  regs.leader_decel_estimate = val[12:0];
				gcf_pkg::REG_LEADER_LENGTH: regs.leader_length = val[12:0];
				default: ;
			endcase
		endfunction

		function longint unsigned root_floor(longint unsigned x);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > x) b >>= 2;
			while (b != 0) begin
				if (x >= res + b) begin
					x -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function longint sat(longint x, longint lo, longint hi);
			return x < lo ? lo : (x > hi ? hi : x);
		endfunction

		// free-flow candidate: v + 2.5*a*tau*(1 - v/V)*sqrt(0.025 + v/V)
		function longint free_flow_speed(longint unsigned v);
			longint unsigned vd, ratio, s, om, p, k, q, lo, mag;
			bit over;
			longint r;
			vd = regs.desired_speed != 0 ? longint'(regs.desired_speed) : 1;
			ratio = (v << 16) / vd;
			s = root_floor((ratio + 1638) << 16);
			over = ratio > 65536;
			om = over ? ratio - 65536 : 65536 - ratio;
			p = (om * s) >> 16;
			k = 5 * longint'(regs.max_accel) * longint'(regs.reaction_time);
			q = k * (p >> 20);
			lo = k * (p & 64'hFFFFF);
			mag = (q >> 7) + ((((q & 127) << 20) + lo) >> 27);
			r = over ? longint'(v) - longint'(mag) : longint'(v) + longint'(mag);
			return sat(r, 0, 65535);
		endfunction

		// note an accepted item: load the state or predict the step result
		function void note_item(vehicle_item_t it);
			longint v, x, xl, ul, xnow, unow, b, c, bt, rad_a, d, rad, ff, cf, vn;
			longint acc, pos, spc, dt, tau;
			step_result_t e;
			if (it.op == OPC_LOAD) begin
				speed_now = it.init_speed;
				position_now = it.init_position;
				return;
			end
			tau = longint'(regs.reaction_time);
			v = longint'(speed_now);
			x = longint'($signed(position_now));
			xl = longint'(it.leader_pos_prev);
			ul = it.leader_speed_known ? longint'(it.leader_speed_prev) : 0;
			xnow = longint'(it.leader_pos_now);
			unow = longint'(it.leader_speed_now);
			ff = free_flow_speed(v);
			b = longint'($signed(regs.desired_decel));
			c = longint'($signed(regs.leader_decel_estimate));
			if (c == 0) c = -1;
			bt = b * tau;
			// the square is never negative, so an arithmetic shift floors it
			rad_a = (bt * bt) >>> 20;
			d = 2 * (xl - longint'(regs.leader_length) - x) - ((v * tau) >>> 10)
				- (ul * ul) / c;
			rad = rad_a - b * d;
			if (rad < 0) begin
				e.radicand_negative = 1'b1;
				cf = 0;
			end else begin
				e.radicand_negative = 1'b0;
				cf = sat(bt / 1024 + longint'(root_floor(rad)), -65535, 65535);
			end
			vn = ff < cf ? ff : cf;
			if (vn < 0) vn = 0;
			dt = regs.time_step != 0 ? longint'(regs.time_step) : 1;
			acc = sat(((vn - v) * 1024) / dt, -32768, 32767);
			pos = sat(x + ((v + vn) * dt) / 2048, -64'sd2147483648, 64'sd2147483647);
			spc = sat(xnow - pos, -64'sd2147483648, 64'sd2147483647);
			speed_now = vn[15:0];
			position_now = pos[31:0];
			e.follower_speed = vn[15:0];
			e.follower_position = pos[31:0];
			e.acceleration = acc[15:0];
			e.spacing = spc[31:0];
			e.speed_diff = 17'(vn - unow);
			e.free_speed = ff[15:0];
			e.follow_speed = cf[16:0];
			pending_steps.push_back(e);
		endfunction

		function void compare_field(string name, logic [63:0] exp, logic [63:0] act);
			if (exp !== act) begin
				errors++;
				$display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp, act);
			end
		endfunction

		// check one accepted result against the oldest expectation
		function void check_result(step_result_t r);
			step_result_t e;
			if (pending_steps.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, got speed %0h",
					$time, r.follower_speed);
				return;
			end
			e = pending_steps.pop_front();
			checked++;
			compare_field("follower_speed", e.follower_speed, r.follower_speed);
			compare_field("follower_position", e.follower_position, r.follower_position);
			compare_field("acceleration", e.acceleration, r.acceleration);
			compare_field("spacing", e.spacing, r.spacing);
			compare_field("speed_diff", e.speed_diff, r.speed_diff);
			compare_field("free_speed", e.free_speed, r.free_speed);
			compare_field("follow_speed", e.follow_speed, r.follow_speed);
			compare_field("radicand_negative", e.radicand_negative, r.radicand_negative);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic item_valid = 1'b0;
	logic item_stall;
	logic op = 1'b0;
	logic signed [31:0] init_position = '0;
	logic [15:0] init_speed = '0;
	logic signed [31:0] leader_pos_prev = '0;
	logic [15:0] leader_speed_prev = '0;
	logic leader_speed_known = 1'b0;
	logic signed [31:0] leader_pos_now = '0;
	logic [15:0] leader_speed_now = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [15:0] follower_speed;
	logic signed [31:0] follower_position;
	logic signed [15:0] acceleration;
	logic signed [31:0] spacing;
	logic signed [16:0] speed_diff;
	logic [15:0] free_speed;
	logic signed [16:0] follow_speed;
	logic radicand_negative;

	follower_tracker tracker = new();
	int burst_left = 0;

	gipps_car_following_step dut (.*);

	always #5 clk = ~clk;

	// watch both handshakes
	always @(posedge clk) begin
		step_result_t r;
		if (arst_n && item_valid && !item_stall) begin
			tracker.note_item('{op, init_position, init_speed, leader_pos_prev,
				leader_speed_prev, leader_speed_known, leader_pos_now, leader_speed_now});
		end
		if (arst_n && result_valid && !result_stall) begin
			r.follower_speed = follower_speed;
			r.follower_position = follower_position;
			r.acceleration = acceleration;
			r.spacing = spacing;
			r.speed_diff = speed_diff;
			r.free_speed = free_speed;
			r.follow_speed = follow_speed;
			r.radicand_negative = radicand_negative;
			tracker.check_result(r);
		end
	end

	// receiver stall pattern: modes change now and then, one long hold-off
	int stall_mode = 0, mode_left = 0, hold_left = 0;
	bit held_once = 0;
	always @(negedge clk) begin
		if (!held_once && tracker.checked >= 300) begin
			held_once = 1;
			hold_left = 3000;
		end
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(50, 1500);
		end else begin
			mode_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			case (stall_mode)
				0: result_stall <= 1'b0;
				1: result_stall <= ($urandom_range(0, 3) == 0);
				2: result_stall <= ($urandom_range(0, 1) == 0);
				default: result_stall <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	task automatic apb_write(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		tracker.write_reg(idx, val);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic write_all(logic [15:0] ts, logic [15:0] tau, logic [11:0] a,
			logic [12:0] b, logic [15:0] vd, logic [12:0] bc, logic [12:0] len);
		apb_write(gcf_pkg::REG_TIME_STEP, 32'(ts));
		apb_write(gcf_pkg::REG_REACTION_TIME, 32'(tau));
		apb_write(gcf_pkg::REG_MAX_ACCEL, 32'(a));
		apb_write(gcf_pkg::REG_DESIRED_DECEL, 32'(b));
		apb_write(gcf_pkg::REG_DESIRED_SPEED, 32'(vd));
		apb_write(gcf_pkg::REG_LEADER_DECEL, 32'(bc));
		apb_write(gcf_pkg::REG_LEADER_LENGTH, 32'(len));
	endtask

	// offer one item; bursts keep valid high, gaps drop it
	task automatic send_item(vehicle_item_t it);
		@(negedge clk);
		item_valid <= 1'b1;
		op <= it.op;
		init_position <= it.init_position;
		init_speed <= it.init_speed;
		leader_pos_prev <= it.leader_pos_prev;
		leader_speed_prev <= it.leader_speed_prev;
		leader_speed_known <= it.leader_speed_known;
		leader_pos_now <= it.leader_pos_now;
		leader_speed_now <= it.leader_speed_now;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat ($urandom_range(0, 12)) @(negedge clk);
			burst_left = $urandom_range(0, 6);
		end
	endtask

	// hold the sender until every expected result is back
	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (tracker.pending_steps.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] clamp32(longint x);
		if (x > 64'sd2147483647) return 32'h7FFFFFFF;
		if (x < -64'sd2147483648) return 32'h80000000;
		return x[31:0];
	endfunction

	// mostly plausible traffic around the follower, some loads and raw noise
	function automatic vehicle_item_t make_item();
		vehicle_item_t it;
		longint x, gap;
		int kind;
		kind = $urandom_range(0, 99);
		it.op = OPC_STEP;
		it.init_position = $urandom;
		it.init_speed = 16'($urandom);
		it.leader_pos_prev = $urandom;
		it.leader_speed_prev = 16'($urandom);
		it.leader_speed_known = $urandom_range(0, 4) != 0;
		it.leader_pos_now = $urandom;
		it.leader_speed_now = 16'($urandom);
		if (kind < 8) begin
			it.op = OPC_LOAD;
			if (kind < 5) it.init_speed = 16'($urandom_range(0, 12000));
		end else if (kind >= 15) begin
			x = longint'($signed(tracker.position_now));
			gap = longint'($urandom_range(0, 60000)) - 4000;
			it.leader_pos_prev = clamp32(x + gap);
			it.leader_pos_now = clamp32(x + gap + $urandom_range(0, 2000));
			it.leader_speed_prev = 16'($urandom_range(0, 12000));
			it.leader_speed_now = 16'($urandom_range(0, 12000));
		end
		return it;
	endfunction

	function automatic vehicle_item_t load_item(logic [31:0] pos, logic [15:0] spd);
		vehicle_item_t it;
		it = '{OPC_LOAD, pos, spd, 0, 0, 0, 0, 0};
		return it;
	endfunction

	function automatic vehicle_item_t step_item(logic [31:0] lpp, logic [15:0] lsp,
			bit known, logic [31:0] lpn, logic [15:0] lsn);
		vehicle_item_t it;
		it = '{OPC_STEP, 0, 0, lpp, lsp, known, lpn, lsn};
		return it;
	endfunction

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes, unknown leader speed, negative radicand, saturation
		send_item(step_item(32'd20000, 16'd5000, 1, 32'd21000, 16'd5000));
		send_item(step_item(32'd20000, 16'd5000, 0, 32'd21000, 16'd0));
		send_item(step_item(32'd100, 16'd0, 1, 32'd100, 16'd65535));
		send_item(load_item(32'h7FFFFF00, 16'hFFFF));
		send_item(step_item(32'h7FFFFFFF, 16'hFFFF, 1, 32'h7FFFFFFF, 16'hFFFF));
		send_item(step_item(32'h80000000, 16'hFFFF, 1, 32'h80000000, 16'd0));
		send_item(load_item(32'h80000000, 16'd0));
		send_item(step_item(32'h80000000, 16'd0, 1, 32'h7FFFFFFF, 16'd0));
		send_item(load_item(32'd0, 16'd7680));
		send_item(step_item(32'hFFFF0000, 16'd8000, 1, 32'hFFFF0000, 16'd8000));
		send_item(step_item(32'hFFFFFFFF, 16'hFFFF, 0, 32'h00000000, 16'hFFFF));
		send_item(load_item(32'd50000, 16'd3000));
		send_item(step_item(32'd53000, 16'd3000, 1, 32'd53800, 16'd3100));
		send_item(step_item(32'd56000, 16'd2500, 1, 32'd56500, 16'd0));
		send_item(load_item(32'd0, 16'd20000));
		send_item(step_item(32'd1000000, 16'd0, 1, 32'd1000000, 16'd0));
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: write_all(16'd1, 16'd1, 12'd1, 13'h1FFF, 16'd1, 13'h1FFF, 13'd0);
				1: write_all(16'hFFFF, 16'hFFFF, 12'hFFF, 13'h1001, 16'hFFFF, 13'h1001,
					13'h1FFF);
				2: write_all(16'd1024, 16'd682, 12'd512, 13'h1D00, 16'd7680, 13'h1D00,
					13'd1664);
				default: write_all(16'($urandom_range(64, 4096)),
					16'($urandom_range(200, 3000)), 12'($urandom_range(1, 4095)),
					13'(-$urandom_range(1, 4095)), 16'($urandom_range(1000, 65535)),
					13'(-$urandom_range(1, 4095)), 13'($urandom_range(0, 8191)));
			endcase
			for (int i = 0; i < 218; i++) send_item(make_item());
			drain();
		end

		repeat (600) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending_steps.size() == 0)
			$display("gipps_car_following_step regression: pass");
		else
			$display("gipps_car_following_step regression: fail");
		$finish;
	end

	initial begin
		#60ms;
		$display("gipps_car_following_step regression: fail");
		$finish;
	end

endmodule
